// ===== design/kgt_pkg.sv =====
// ----------------------------------------------------------------------------
// kgt_pkg: shared types and constants for the grid basis-change block
// Request payloads, opcodes, status codes and controller states.
// ----------------------------------------------------------------------------
package kgt_pkg;

  localparam int MAX_POINTS_PER_AXIS = 8;
  localparam int MAX_COMPONENTS      = 9;

  typedef enum logic [1:0] {
    OP_WR_WEIGHT = 2'd0,
    OP_WR_VECTOR = 2'd1,
    OP_RUN       = 2'd2,
    OP_READ      = 2'd3
  } opcode_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_IDX = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_DOF       = 2'd1;
  localparam logic [1:0] REG_POINTS    = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         axis;
    logic [12:0]        element_index;
    logic signed [31:0] write_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } out_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_MAC,
    S_DRAIN,
    S_STORE,
    S_DONE
  } ctl_state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic copy_en;      // copy step of the run
    logic copy_start;
    logic mac_start;    // clear accumulator, load first source index
    logic mac_issue;    // issue one weight/vector fetch
    logic store;        // write accumulated element
    logic next_elem;    // advance output element
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic copy_last;
    logic issue_last;
    logic pipe_empty;
    logic elem_last;
  } dp_stat_t;

endpackage

// ===== design/kgt_datapath.sv =====
// ----------------------------------------------------------------------------
// kgt_datapath: memories, index counters and multiply-accumulate pipeline
// Holds weight tables, grid vector and source copy; runs one MAC per cycle while issuing.
// ----------------------------------------------------------------------------
module kgt_datapath
  import kgt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        dir,
  input  logic [3:0]  n_eff,
  input  logic [3:0]  dof_eff,
  input  logic        wr_w_en,
  input  logic [1:0]  wr_w_axis,
  input  logic [12:0] wr_idx,
  input  logic [31:0] wr_val,
  input  logic        wr_v_en,
  input  logic [12:0] rd_idx,
  output logic [31:0] rd_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        sat_flag
);

  localparam int MAX_N   = MAX_POINTS_PER_AXIS;
  localparam int MAX_DOF = MAX_COMPONENTS;
  localparam int CUBE  = MAX_N * MAX_N * MAX_N;
  localparam int TBL   = CUBE * MAX_N;
  localparam int VEC   = CUBE * MAX_DOF;
  localparam int TW    = $clog2(TBL);
  localparam int VW    = $clog2(VEC);
  localparam int PW    = $clog2(CUBE);
  localparam int AW    = $clog2(MAX_N);
  localparam int CW    = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;

  logic [31:0] w0_mem [TBL];
  logic [31:0] w1_mem [TBL];
  logic [31:0] w2_mem [TBL];
  logic [31:0] gv_mem [VEC];
  logic [31:0] sc_mem [VEC];

  logic [PW:0]   n3;
  logic [VW:0]   vlen;
  assign n3   = (PW+1)'(n_eff * n_eff * n_eff);
  assign vlen = (VW+1)'(n3 * dof_eff);

  // output element: point o, component c; source point s
  logic [PW-1:0] o_r, s_r;
  logic [CW-1:0] c_r, c_step;
  logic [VW-1:0] copy_r;
  logic [VW-1:0] src_addr_r, dst_addr_r;

  assign c_step = (c_r == CW'(dof_eff - 1'b1)) ? '0 : c_r + 1'b1;

  // row (digits) is o for forward, s for reverse; column k is the other
  logic [AW-1:0] o1_r, o2_r, o3_r, s1_r, s2_r, s3_r;
  logic [AW-1:0] a1, a2, a3;
  logic [PW-1:0] kcol;
  assign a1   = dir ? s1_r : o1_r;
  assign a2   = dir ? s2_r : o2_r;
  assign a3   = dir ? s3_r : o3_r;
  assign kcol = dir ? o_r : s_r;

  logic [TW-1:0] ia0, ia1, ia2;
  assign ia0 = TW'(a1 * n3 + kcol);
  assign ia1 = TW'(a2 * n3 + kcol);
  assign ia2 = TW'(a3 * n3 + kcol);

  always_ff @(posedge clk) begin
    if (wr_w_en && wr_w_axis == 2'd0) w0_mem[wr_idx[TW-1:0]] <= wr_val;
    if (wr_w_en && wr_w_axis == 2'd1) w1_mem[wr_idx[TW-1:0]] <= wr_val;
    if (wr_w_en && wr_w_axis == 2'd2) w2_mem[wr_idx[TW-1:0]] <= wr_val;
  end

  // pipeline stage 1: fetch
  logic [31:0] wa_r, wb_r, wc_r, x_r, cp_r;
  logic        v1_r, v2_r, v3_r, v4_r, cpv_r;
  logic [VW-1:0] cp_addr_r;
  always_ff @(posedge clk) begin
    wa_r <= w0_mem[ia0];
    wb_r <= w1_mem[ia1];
    wc_r <= w2_mem[ia2];
    x_r  <= sc_mem[src_addr_r];
  end

  logic [31:0] acc_out;

  // grid vector port: host write, run store, copy read, host read
  always_ff @(posedge clk) begin
    if (wr_v_en) gv_mem[wr_idx[VW-1:0]] <= wr_val;
    else if (cmd.store) gv_mem[dst_addr_r] <= acc_out;
    cp_r <= gv_mem[cmd.copy_en ? copy_r : rd_idx[VW-1:0]];
  end
  assign rd_data = cp_r;

  always_ff @(posedge clk) begin
    if (cpv_r) sc_mem[cp_addr_r] <= cp_r;
  end

  // stage 2: p = a*b
  logic signed [63:0] pab_r, pc_prod_r, wx_r;
  logic signed [31:0] c2_r, x2_r, c3_r, x3_r, x4_r, x5_r, p_r, w_r;
  logic               satp_r, satw_r;

  function automatic logic signed [31:0] rsat(input logic signed [63:0] v,
                                              output logic f);
    logic signed [63:0] t;
    t = (v + 64'sd536870912) >>> 30;
    f = 1'b0;
    if (t > 64'sd2147483647) begin
      f = 1'b1;
      return 32'sh7fffffff;
    end
    if (t < -64'sd2147483648) begin
      f = 1'b1;
      return 32'sh80000000;
    end
    return t[31:0];
  endfunction

  logic signed [31:0] p_nxt, w_nxt;
  logic               fp, fw;
  always_comb begin
    p_nxt = rsat(pab_r, fp);
    w_nxt = rsat(pc_prod_r, fw);
  end

  logic v5_r, v6_r;
  always_ff @(posedge clk) begin
    pab_r     <= $signed(wa_r) * $signed(wb_r);
    c2_r      <= wc_r;
    x2_r      <= x_r;
    p_r       <= p_nxt;
    satp_r    <= fp;
    c3_r      <= c2_r;
    x3_r      <= x2_r;
    pc_prod_r <= p_r * c3_r;
    x4_r      <= x3_r;
    w_r       <= w_nxt;
    satw_r    <= fw;
    x5_r      <= x4_r;
    wx_r      <= w_r * x5_r;
  end

  logic signed [63:0] acc_r;
  logic signed [63:0] term;
  assign term = (wx_r + 64'sd32768) >>> 16;

  logic signed [63:0] fin;
  logic               sat_fin;
  assign fin = (acc_r + 64'sd8192) >>> 14;
  always_comb begin
    sat_fin = 1'b0;
    acc_out = fin[31:0];
    if (fin > 64'sd2147483647) begin
      sat_fin = 1'b1;
      acc_out = 32'h7fffffff;
    end else if (fin < -64'sd2147483648) begin
      sat_fin = 1'b1;
      acc_out = 32'h80000000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
      cpv_r <= 1'b0;
      sat_flag <= 1'b0;
      acc_r <= '0;
    end else begin
      v1_r  <= cmd.mac_issue;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      cpv_r <= cmd.copy_en;
      if (cmd.copy_start) sat_flag <= 1'b0;
      else begin
        if (v3_r && satp_r) sat_flag <= 1'b1;
        if (v5_r && satw_r) sat_flag <= 1'b1;
        if (cmd.store && sat_fin) sat_flag <= 1'b1;
      end
      if (cmd.mac_start) acc_r <= '0;
      else if (v6_r) acc_r <= acc_r + term;
    end
  end
  // v6_r marks wx_r valid: issue->x_r(1)->pab(2)->p(3)->pc(4)->w(5)->wx(6)
  assign stat.pipe_empty = !(v1_r | v2_r | v3_r | v4_r | v5_r | v6_r | cmd.mac_issue);

  always_ff @(posedge clk) begin
    cp_addr_r <= copy_r;
    if (cmd.copy_start) copy_r <= '0;
    else if (cmd.copy_en) copy_r <= copy_r + 1'b1;
  end
  assign stat.copy_last = ((VW+1)'(copy_r) == vlen - 1'b1);

  // source counter with digits
  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      s_r <= '0; s1_r <= '0; s2_r <= '0; s3_r <= '0;
      src_addr_r <= VW'(cmd.next_elem ? c_step : c_r);
    end else if (cmd.mac_issue) begin
      s_r <= s_r + 1'b1;
      src_addr_r <= src_addr_r + VW'(dof_eff);
      if (s3_r == AW'(n_eff - 1'b1)) begin
        s3_r <= '0;
        if (s2_r == AW'(n_eff - 1'b1)) begin
          s2_r <= '0;
          s1_r <= s1_r + 1'b1;
        end else s2_r <= s2_r + 1'b1;
      end else s3_r <= s3_r + 1'b1;
    end
  end
  assign stat.issue_last = ((PW+1)'(s_r) == n3 - 1'b1);

  // output element counter
  always_ff @(posedge clk) begin
    if (cmd.copy_start) begin
      o_r <= '0; c_r <= '0; o1_r <= '0; o2_r <= '0; o3_r <= '0;
      dst_addr_r <= '0;
    end else if (cmd.next_elem) begin
      dst_addr_r <= dst_addr_r + 1'b1;
      c_r <= c_step;
      if (c_r == CW'(dof_eff - 1'b1)) begin
        o_r <= o_r + 1'b1;
        if (o3_r == AW'(n_eff - 1'b1)) begin
          o3_r <= '0;
          if (o2_r == AW'(n_eff - 1'b1)) begin
            o2_r <= '0;
            o1_r <= o1_r + 1'b1;
          end else o2_r <= o2_r + 1'b1;
        end else o3_r <= o3_r + 1'b1;
      end
    end
  end
  assign stat.elem_last = ((VW+1)'(dst_addr_r) == vlen - 1'b1);

endmodule

// ===== design/kgt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kgt_ctrl: request handling and run sequencer
// Accepts requests, checks indexes, steps the transform, holds the response.
// ----------------------------------------------------------------------------
module kgt_ctrl
  import kgt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_req,
  input  logic [3:0] n_eff,
  input  logic [3:0] dof_eff,
  input  logic [31:0] rd_data,
  input  logic     sat_flag,
  output logic     wr_w_en,
  output logic     wr_v_en,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;
  logic       rd_pend_r, out_valid_r;
  out_req_t   out_r;

  logic [12:0] n3, n4, vlen;
  assign n3   = 13'(n_eff * n_eff * n_eff);
  assign n4   = 13'(n3 * n_eff);
  assign vlen = 13'(n3 * dof_eff);

  logic acc_in, bad, good_read;
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready) && !rd_pend_r;
  assign acc_in   = in_valid && in_ready;
  always_comb begin
    case (opcode_t'(in_req.opcode))
      OP_WR_WEIGHT: bad = (in_req.axis > 2'd2) || (in_req.element_index >= n4);
      OP_WR_VECTOR: bad = in_req.element_index >= vlen;
      OP_READ:      bad = in_req.element_index >= vlen;
      default:      bad = 1'b0;
    endcase
  end
  assign wr_w_en   = acc_in && in_req.opcode == OP_WR_WEIGHT && !bad;
  assign wr_v_en   = acc_in && in_req.opcode == OP_WR_VECTOR && !bad;
  assign good_read = in_req.opcode == OP_READ && !bad;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (acc_in && in_req.opcode == OP_RUN) state_nxt = S_COPY;
      S_COPY:  if (stat.copy_last) state_nxt = S_MAC;
      S_MAC:   if (stat.issue_last) state_nxt = S_DRAIN;
      S_DRAIN: if (stat.pipe_empty) state_nxt = S_STORE;
      S_STORE: state_nxt = stat.elem_last ? S_DONE : S_MAC;
      S_DONE:  if (!out_valid_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE:  cmd.copy_start = acc_in && in_req.opcode == OP_RUN;
      S_COPY: begin
        cmd.copy_en   = 1'b1;
        cmd.mac_start = stat.copy_last;
      end
      S_MAC:   cmd.mac_issue = 1'b1;
      S_STORE: begin
        cmd.store     = 1'b1;
        cmd.next_elem = 1'b1;
        cmd.mac_start = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= acc_in && good_read;
      if (rd_pend_r || (state_r == S_DONE && !out_valid_r) ||
          (acc_in && in_req.opcode != OP_RUN && !good_read))
        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      out_r.read_value <= '0;
      out_r.status     <= bad ? ST_IDX : ST_OK;
    end
    if (rd_pend_r) out_r.read_value <= rd_data;
    if (state_r == S_DONE && !out_valid_r) begin
      out_r.read_value <= '0;
      out_r.status     <= sat_flag ? ST_SAT : ST_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

endmodule

// ===== design/kronecker_grid_transform.sv =====
// ----------------------------------------------------------------------------
// kronecker_grid_transform: tensor-product grid basis change
// Load, transform and read back a grid vector with per-axis weight tables.
// ----------------------------------------------------------------------------
// Writes respond in the cycle after they are taken; a read passes a pending
// register that holds off new requests. Throughput: one load request per cycle
// while responses are taken. Run: copy, then MACs one per cycle on one pipe.
// Reset: synchronous; registers return to direction 0, dof 9, n 8; memories
// keep their contents and read as undefined until written.
module kronecker_grid_transform
  import kgt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_req_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic       dir_r;
  logic [3:0] dof_r, n_r, n_eff, dof_eff;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      dof_r <= 4'd9;
      n_r   <= 4'd8;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        REG_DIRECTION: dir_r <= cfg_pwdata[0];
        REG_DOF:       dof_r <= cfg_pwdata[3:0];
        REG_POINTS:    n_r   <= cfg_pwdata[3:0];
        default:       ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      REG_DIRECTION: cfg_prdata = {31'd0, dir_r};
      REG_DOF:       cfg_prdata = {28'd0, dof_r};
      REG_POINTS:    cfg_prdata = {28'd0, n_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign n_eff = (n_r < 4'd2) ? 4'd2 :
                 (n_r > 4'(MAX_POINTS_PER_AXIS)) ? 4'(MAX_POINTS_PER_AXIS) : n_r;
  assign dof_eff = (dof_r < 4'd1) ? 4'd1 :
                   (dof_r > 4'(MAX_COMPONENTS)) ? 4'(MAX_COMPONENTS) : dof_r;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        wr_w_en, wr_v_en, sat_flag;
  logic [31:0] rd_data;

  kgt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_req(in_data),
    .out_valid, .out_ready, .out_req(out_data),
    .n_eff, .dof_eff, .rd_data, .sat_flag, .wr_w_en, .wr_v_en, .stat, .cmd
  );

  kgt_datapath u_dp (
    .clk, .rst_n, .dir(dir_r), .n_eff, .dof_eff,
    .wr_w_en, .wr_w_axis(in_data.axis), .wr_idx(in_data.element_index),
    .wr_val(in_data.write_value), .wr_v_en, .rd_idx(in_data.element_index),
    .rd_data, .cmd, .stat, .sat_flag
  );

  a_no_dual_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_w_en && wr_v_en)) else $error("weight and vector write together");
  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mac_issue || cmd.copy_en) |-> !in_ready) else $error("ready during run");
  a_store_not_issue: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.store && cmd.mac_issue)) else $error("store during issue");

endmodule

// ===== sim/kgt_checker.sv =====
// ----------------------------------------------------------------------------
// kgt_checker: scoreboard for the grid basis-change block
// Watches the request, response and register ports, keeps its own copy of the
// weight tables, grid vector and registers, predicts each response and
// compares it field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module kgt_checker
  import kgt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_req_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_req_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX  = 8;
  localparam int DMAX  = 9;
  localparam int CUBE  = NMAX * NMAX * NMAX;
  localparam int TBL   = CUBE * NMAX;
  localparam int VSIZE = CUBE * DMAX;

  logic [31:0] weight_mem [3*TBL];
  logic [31:0] grid_mem   [VSIZE];
  logic [31:0] src_mem    [VSIZE];
  logic        dir_q;
  logic [3:0]  dof_q;
  logic [3:0]  pts_q;
  bit          clipped;
  out_req_t    response_q [$];

  assign pending = response_q.size();

  function automatic int grid_n();
    int n;
    n = pts_q;
    if (n < 2) n = 2;
    if (n > NMAX) n = NMAX;
    return n;
  endfunction

  function automatic int grid_dof();
    int d;
    d = dof_q;
    if (d < 1) d = 1;
    if (d > DMAX) d = DMAX;
    return d;
  endfunction

  function automatic longint round_down(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint kron_weight(int n, int n3, int r, int k);
    longint a, b, c, p;
    a = longint'($signed(weight_mem[r / (n * n) * n3 + k]));
    b = longint'($signed(weight_mem[TBL + ((r / n) % n) * n3 + k]));
    c = longint'($signed(weight_mem[2 * TBL + (r % n) * n3 + k]));
    p = clip32(round_down(a * b, 30));
    return clip32(round_down(p * c, 30));
  endfunction

  task automatic transform_grid(output bit sat);
    int     n, n3, dof;
    longint acc, w, x;
    n   = grid_n();
    n3  = n * n * n;
    dof = grid_dof();
    clipped = 0;
    for (int i = 0; i < VSIZE; i++) src_mem[i] = grid_mem[i];
    for (int o = 0; o < n3; o++) begin
      for (int c = 0; c < dof; c++) begin
        acc = 0;
        for (int s = 0; s < n3; s++) begin
          w = dir_q ? kron_weight(n, n3, s, o) : kron_weight(n, n3, o, s);
          x = longint'($signed(src_mem[s * dof + c]));
          acc += round_down(w * x, 16);
        end
        grid_mem[o * dof + c] = 32'(clip32(round_down(acc, 14)));
      end
    end
    sat = clipped;
  endtask

  task automatic predict_response(input in_req_t r);
    out_req_t e;
    int       n, vlen, idx;
    bit       sat;
    n    = grid_n();
    vlen = n * n * n * grid_dof();
    idx  = r.element_index;
    e    = '{read_value: '0, status: ST_OK};
    case (opcode_t'(r.opcode))
      OP_WR_WEIGHT: begin
        if (r.axis > 2 || idx >= n * n * n * n) e.status = ST_IDX;
        else weight_mem[r.axis * TBL + idx] = r.write_value;
      end
      OP_WR_VECTOR: begin
        if (idx >= vlen) e.status = ST_IDX;
        else grid_mem[idx] = r.write_value;
      end
      OP_RUN: begin
        transform_grid(sat);
        if (sat) e.status = ST_SAT;
      end
      default: begin
        if (idx >= vlen) e.status = ST_IDX;
        else e.read_value = grid_mem[idx];
      end
    endcase
    response_q.push_back(e);
  endtask

  always @(posedge clk) begin
    out_req_t e;
    if (!rst_n) begin
      dir_q  <= 1'b0;
      dof_q  <= 4'd9;
      pts_q  <= 4'd8;
      errors <= 0;
      response_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_DIRECTION: dir_q <= cfg_pwdata[0];
          REG_DOF:       dof_q <= cfg_pwdata[3:0];
          REG_POINTS:    pts_q <= cfg_pwdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_response(in_data);
      if (out_valid && out_ready) begin
        if (response_q.size() == 0) begin
          $display("%0t: response with none expected: value %h status %0d",
                   $time, out_data.read_value, out_data.status);
          errors <= errors + 1;
        end else begin
          e = response_q.pop_front();
          if (e.read_value !== out_data.read_value || e.status !== out_data.status) begin
            $display("%0t: mismatch: expected value %h status %0d, got value %h status %0d",
                     $time, e.read_value, e.status, out_data.read_value, out_data.status);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/kronecker_grid_transform_tb.sv =====
// ----------------------------------------------------------------------------
// kronecker_grid_transform_tb: stimulus and verdict for the grid transform
// Loads weight tables and grid vectors under several register settings, runs
// forward and transposed transforms, reads results back and mixes in bad
// indexes, with random request gaps and response stalls.
// ----------------------------------------------------------------------------
module kronecker_grid_transform_tb;
  import kgt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 100000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_req_t     in_data;
  logic        out_valid;
  logic        out_ready;
  out_req_t    out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          errors;
  int          pending;
  int          stall_cycles;
  bit          steady;
  bit          vec_seen [4608];
  int          cur_n;
  int          cur_dof;

  kronecker_grid_transform u_dut (.*);

  kgt_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady || $urandom_range(99) >= 31;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word(bit wide);
    if (wide) return $urandom;
    return $urandom_range(0, 32'h3fff_ffff) - 32'h2000_0000;
  endfunction

  task automatic send(logic [1:0] op, logic [1:0] ax, int idx, logic [31:0] val);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, axis: ax, element_index: idx[12:0], write_value: val};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] reg_idx, int val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_grid(int vlen);
    send(OP_RUN, 2'($urandom), $urandom_range(8191), $urandom);
    for (int i = 0; i < vlen; i++) vec_seen[i] = 1;
  endtask

  task automatic phase(int dir, int dof_raw, int n_raw, int count, bit allow_run, bit wide);
    int n4, vlen, sel, ax, idx;
    settle();
    cfg_write(REG_DIRECTION, dir);
    cfg_write(REG_DOF, dof_raw);
    cfg_write(REG_POINTS, n_raw);
    cur_n   = n_raw < 2 ? 2 : (n_raw > 8 ? 8 : n_raw);
    cur_dof = dof_raw < 1 ? 1 : (dof_raw > 9 ? 9 : dof_raw);
    n4      = cur_n ** 4;
    vlen    = cur_n ** 3 * cur_dof;
    if (allow_run) begin
      for (int a = 0; a < 3; a++)
        for (int i = 0; i < n4; i++) send(OP_WR_WEIGHT, 2'(a), i, rand_word(wide));
      for (int i = 0; i < vlen; i++) begin
        send(OP_WR_VECTOR, 2'($urandom), i, rand_word(1'($urandom_range(1))));
        vec_seen[i] = 1;
      end
      run_grid(vlen);
    end
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        ax  = $urandom_range(9) == 0 ? 3 : $urandom_range(2);
        idx = $urandom_range(9) == 0 ? $urandom_range(8191) : $urandom_range(n4 - 1);
        send(OP_WR_WEIGHT, 2'(ax), idx, rand_word(wide));
      end else if (sel < 65) begin
        idx = $urandom_range(9) == 0 ? $urandom_range(8191) : $urandom_range(vlen - 1);
        send(OP_WR_VECTOR, 2'($urandom), idx, rand_word(1'($urandom_range(1))));
        if (idx < vlen) vec_seen[idx] = 1;
      end else if (sel < 90 || !allow_run) begin
        idx = $urandom_range(7) == 0 ? $urandom_range(vlen, 8191) : $urandom_range(vlen - 1);
        if (idx < vlen && !vec_seen[idx]) begin
          send(OP_WR_VECTOR, 2'($urandom), idx, $urandom);
          vec_seen[idx] = 1;
        end else begin
          send(OP_READ, 2'($urandom), idx, $urandom);
        end
      end else begin
        run_grid(vlen);
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    steady      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_WR_WEIGHT, 2'd0, 0, 32'h8000_0000);
    send(OP_WR_WEIGHT, 2'd2, 4095, 32'h7fff_ffff);
    send(OP_WR_WEIGHT, 2'd3, 0, 32'h0000_0001);
    send(OP_WR_WEIGHT, 2'd1, 4096, 32'hffff_ffff);
    send(OP_WR_WEIGHT, 2'd1, 8191, 32'h0000_0000);
    send(OP_WR_VECTOR, 2'd3, 0, 32'h8000_0000);
    send(OP_WR_VECTOR, 2'd0, 4607, 32'h7fff_ffff);
    send(OP_WR_VECTOR, 2'd2, 4608, 32'hffff_ffff);
    send(OP_WR_VECTOR, 2'd1, 8191, 32'h0000_0000);
    vec_seen[0]    = 1;
    vec_seen[4607] = 1;
    send(OP_READ, 2'd0, 0, 32'hffff_ffff);
    send(OP_READ, 2'd3, 4607, 32'h0000_0000);
    send(OP_READ, 2'd1, 4608, 32'h1234_5678);
    send(OP_READ, 2'd2, 8191, 32'h8765_4321);

    phase(0, 1, 2, 60, 1'b1, 1'b0);
    phase(1, 9, 2, 60, 1'b1, 1'b1);
    steady = 1'b1;
    phase(0, 3, 3, 60, 1'b1, 1'b0);
    steady = 1'b0;
    phase(1, 2, 3, 60, 1'b1, 1'b1);
    phase(1, 0, 1, 60, 1'b1, 1'b1);
    phase(0, 15, 15, 80, 1'b0, 1'b1);

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
